### src/vblank_event_scheduler_macros.svh
// assertion macros for the vblank event scheduler
// expects clk and rst_n in the scope where a macro is used
`ifndef VBLANK_EVENT_SCHEDULER_MACROS_SVH
`define VBLANK_EVENT_SCHEDULER_MACROS_SVH

// same-cycle implication, off during reset
`define VBES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define VBES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vbes_pkg.sv
// shared types and constants for the vblank event scheduler
// no dependencies; used by the time unit, the top level and the testbench
package vbes_pkg;

    localparam int TIME_W       = 64;
    localparam int WAKE_W       = 32;
    localparam int INTERVAL_W   = 20;
    localparam int CFG_INDEX_W  = 2;
    localparam int DEFAULT_TABLE_DEPTH = 16;

    // reset values of the configuration registers
    localparam logic [TIME_W-1:0]     TIME_BASE_RST      = '0;
    localparam logic [TIME_W-1:0]     FRAME_BASE_RST     = '0;
    localparam logic [INTERVAL_W-1:0] FRAME_INTERVAL_RST = 20'd16667;

    // shared unit: radix-16 multiply and radix-16 divide by 1000
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_STEPS   = (INTERVAL_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
    localparam int DIV_DIGIT_W = 4;
    localparam int DIV_STEPS   = TIME_W / DIV_DIGIT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int REM_W       = 10;
    localparam int MS_DIVISOR_INT = 1000;
    localparam logic [REM_W:0] MS_DIVISOR = MS_DIVISOR_INT[REM_W:0];

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIME_BASE      = 2'd0,
        CFG_FRAME_BASE     = 2'd1,
        CFG_FRAME_INTERVAL = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_QUEUE = 2'd0,
        CMD_ABORT = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_NOTIFY    = 3'd0,
        KIND_QUEUED    = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_ABORTED   = 3'd3,
        KIND_MISS      = 3'd4,
        KIND_TICK_DONE = 3'd5
    } kind_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [TIME_W-1:0] evt_id;
        logic [TIME_W-1:0] target_frame;
        logic [TIME_W-1:0] now_frame;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TIME_W-1:0] done_id;
        logic [TIME_W-1:0] stamp_time;
        logic [TIME_W-1:0] stamp_frame;
        logic [WAKE_W-1:0] wake_ms;
        logic              wake_valid;
        logic              last;
    } rsp_t;

    typedef enum logic {
        UOP_MUL = 1'b0,
        UOP_DIV = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic done;
    } unit_rsp_t;

endpackage

### src/vbes_stream_if.sv
// valid/ready stream channel carrying one payload beat
// payload type is set per instance, normally from vbes_pkg
interface vbes_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

### src/vbes_time_unit.sv
// shared arithmetic unit: frame to microsecond time, and time to wake milliseconds
// depends on vbes_pkg
module vbes_time_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vbes_pkg::unit_req_t                 ctl,
    input  logic [vbes_pkg::TIME_W-1:0]         operand,
    input  logic [vbes_pkg::TIME_W-1:0]         time_base,
    input  logic [vbes_pkg::TIME_W-1:0]         frame_base,
    input  logic [vbes_pkg::INTERVAL_W-1:0]     interval,
    output vbes_pkg::unit_rsp_t                 status,
    output logic [vbes_pkg::TIME_W-1:0]         time_us,
    output logic [vbes_pkg::WAKE_W-1:0]         wake_ms
);

    localparam int TW = vbes_pkg::TIME_W;
    localparam int RW = vbes_pkg::REM_W;
    localparam int MD = vbes_pkg::MUL_DIGIT_W;
    localparam int DD = vbes_pkg::DIV_DIGIT_W;
    localparam int SW = vbes_pkg::STEP_W;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } ustate_t;

    ustate_t                          state_reg, state_next;
    logic                             done_reg, done_next;
    logic [SW-1:0]                    step_reg, step_next;
    logic [TW-1:0]                    acc_reg, acc_next;
    logic [TW-1:0]                    opd_reg, opd_next;
    logic [vbes_pkg::INTERVAL_W-1:0]  mul_reg, mul_next;
    logic [RW-1:0]                    rem_reg, rem_next;

    logic [TW+MD-1:0]                 part;
    logic [TW-1:0]                    dvd_v;
    logic [RW-1:0]                    rem_v;
    logic [RW:0]                      trial;

    // one digit of interval times the frame delta
    assign part = opd_reg * mul_reg[MD-1:0];

    // four restoring steps of the divide by 1000
    always_comb
    begin
        dvd_v = opd_reg;
        rem_v = rem_reg;
        trial = '0;
        for (int b = 0; b < DD; b++)
        begin
            trial = {rem_v, dvd_v[TW-1]};
            dvd_v = {dvd_v[TW-2:0], 1'b0};
            if (trial >= vbes_pkg::MS_DIVISOR)
            begin
                trial    = trial - vbes_pkg::MS_DIVISOR;
                dvd_v[0] = 1'b1;
            end
            rem_v = trial[RW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        acc_next   = acc_reg;
        opd_next   = opd_reg;
        mul_next   = mul_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    if (ctl.op == vbes_pkg::UOP_MUL)
                    begin
                        opd_next   = operand - frame_base;
                        acc_next   = time_base;
                        mul_next   = interval;
                        step_next  = SW'(vbes_pkg::MUL_STEPS - 1);
                        state_next = U_MUL;
                    end
                    else
                    begin
                        opd_next   = operand;
                        rem_next   = '0;
                        step_next  = SW'(vbes_pkg::DIV_STEPS - 1);
                        state_next = U_DIV;
                    end
                end
            end
            U_MUL:
            begin
                acc_next  = acc_reg + part[TW-1:0];
                opd_next  = {opd_reg[TW-MD-1:0], {MD{1'b0}}};
                mul_next  = mul_reg >> MD;
                step_next = step_reg - SW'(1);
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            U_DIV:
            begin
                opd_next  = dvd_v;
                rem_next  = rem_v;
                step_next = step_reg - SW'(1);
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            acc_reg   <= '0;
            opd_reg   <= '0;
            mul_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            opd_reg   <= opd_next;
            mul_reg   <= mul_next;
            rem_reg   <= rem_next;
        end
    end

    assign status.done = done_reg;
    assign time_us     = acc_reg;
    // quotient sits in opd_reg after a divide
    assign wake_ms     = opd_reg[vbes_pkg::WAKE_W-1:0] + vbes_pkg::WAKE_W'(1);

endmodule

### src/vblank_event_scheduler.sv
// vblank event scheduler top level: pending table, sequencer, output register
// depends on vbes_pkg, vbes_stream_if, vbes_time_unit, vblank_event_scheduler_macros.svh
//
// channel   dir   payload          beat taken when
// req       in    vbes_pkg::req_t  req.valid && req.ready
// rsp       out   vbes_pkg::rsp_t  rsp.valid && rsp.ready
// cfg       in    index + data     cfg_we (no handshake, no read-back)
//
// queue appends; on an empty table it also works out the wake (5-step multiply, 16-step
//   divide by 1000), with a second multiply when the target time has already passed
// abort reads each pending entry; tick the same, plus one notify per reached entry,
//   plus the wake for the next frame when entries remain
// reset clears the count and sequencer, presets the config; table memory is not cleared
// req is taken whenever the sequencer idles; a stalled rsp holds it in its emit step
`include "vblank_event_scheduler_macros.svh"

module vblank_event_scheduler #(
    parameter int TABLE_DEPTH = vbes_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    vbes_stream_if.sink                           req,
    vbes_stream_if.source                         rsp,
    input  logic                                  cfg_we,
    input  logic [vbes_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [vbes_pkg::TIME_W-1:0]           cfg_data
);

    localparam int TW    = vbes_pkg::TIME_W;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_END,
        S_MUL,
        S_CMP,
        S_DIV,
        S_EMIT
    } state_t;

    // configuration registers
    logic [TW-1:0]                   time_base_reg;
    logic [TW-1:0]                   frame_base_reg;
    logic [vbes_pkg::INTERVAL_W-1:0] frame_interval_reg;

    // sequencer state
    state_t          state_reg, state_next;
    state_t          ret_reg, ret_next;
    vbes_pkg::req_t  req_reg, req_next;
    logic [TW-1:0]   next_frame_reg, next_frame_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic            found_reg, found_next;
    logic            second_reg, second_next;
    vbes_pkg::rsp_t  pend_reg, pend_next;
    vbes_pkg::rsp_t  rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // pending table memory, one write and one read port
    logic [TW-1:0]    ids_mem  [TABLE_DEPTH];
    logic [TW-1:0]    tgts_mem [TABLE_DEPTH];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [TW-1:0]    mem_wid;
    logic [TW-1:0]    mem_wtgt;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [TW-1:0]    rd_id_reg;
    logic [TW-1:0]    rd_tgt_reg;

    // shared time unit
    vbes_pkg::unit_req_t         unit_ctl;
    vbes_pkg::unit_rsp_t         unit_sts;
    logic [TW-1:0]               unit_operand;
    logic [TW-1:0]               unit_time;
    logic [vbes_pkg::WAKE_W-1:0] unit_wake;

    // scan helpers
    logic             slot_free;
    logic             is_tick;
    logic             drop;
    logic [CNT_W-1:0] idx_inc;
    logic             more;

    function automatic vbes_pkg::rsp_t make_rsp(
        input logic [2:0]                  kind,
        input logic [TW-1:0]               id,
        input logic [TW-1:0]               st,
        input logic [TW-1:0]               sf,
        input logic [vbes_pkg::WAKE_W-1:0] wake,
        input logic                        wv,
        input logic                        last
    );
        vbes_pkg::rsp_t r;
        r.kind        = kind;
        r.done_id     = id;
        r.stamp_time  = st;
        r.stamp_frame = sf;
        r.wake_ms     = wake;
        r.wake_valid  = wv;
        r.last        = last;
        return r;
    endfunction

    vbes_time_unit u_time (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (unit_ctl),
        .operand    (unit_operand),
        .time_base  (time_base_reg),
        .frame_base (frame_base_reg),
        .interval   (frame_interval_reg),
        .status     (unit_sts),
        .time_us    (unit_time),
        .wake_ms    (unit_wake)
    );

    // config writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_base_reg      <= vbes_pkg::TIME_BASE_RST;
            frame_base_reg     <= vbes_pkg::FRAME_BASE_RST;
            frame_interval_reg <= vbes_pkg::FRAME_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vbes_pkg::CFG_TIME_BASE:      time_base_reg  <= cfg_data;
                vbes_pkg::CFG_FRAME_BASE:     frame_base_reg <= cfg_data;
                vbes_pkg::CFG_FRAME_INTERVAL:
                    frame_interval_reg <= cfg_data[vbes_pkg::INTERVAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // table memory with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ids_mem[mem_waddr]  <= mem_wid;
            tgts_mem[mem_waddr] <= mem_wtgt;
        end
        if (mem_re)
        begin
            rd_id_reg  <= ids_mem[mem_raddr];
            rd_tgt_reg <= tgts_mem[mem_raddr];
        end
    end

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign is_tick   = (req_reg.command == vbes_pkg::CMD_TICK);
    // tick drops every reached entry, abort drops only the first id match
    assign drop      = is_tick ? (req_reg.now_frame >= rd_tgt_reg)
                               : (!found_reg && (rd_id_reg == req_reg.evt_id));
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign more      = (idx_inc < count_reg);

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        req_next        = req_reg;
        next_frame_next = next_frame_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wr_next         = wr_reg;
        found_next      = found_reg;
        second_next     = second_reg;
        pend_next       = pend_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;

        mem_we       = 1'b0;
        mem_waddr    = wr_reg[IDX_W-1:0];
        mem_wid      = rd_id_reg;
        mem_wtgt     = rd_tgt_reg;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg[IDX_W-1:0];
        unit_ctl     = '{start: 1'b0, op: vbes_pkg::UOP_MUL};
        unit_operand = next_frame_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next        = req.payload;
                    next_frame_next = req.payload.now_frame + TW'(1);
                    idx_next        = '0;
                    wr_next         = '0;
                    found_next      = 1'b0;
                    second_next     = 1'b0;
                    unique case (req.payload.command)
                        vbes_pkg::CMD_QUEUE:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                pend_next = make_rsp(vbes_pkg::KIND_FULL, '0, '0, '0,
                                                     '0, 1'b0, 1'b1);
                                ret_next   = S_IDLE;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                // append at the tail
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wid    = req.payload.evt_id;
                                mem_wtgt   = req.payload.target_frame;
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    // first entry arms the wake: time of the target
                                    unit_ctl     = '{start: 1'b1, op: vbes_pkg::UOP_MUL};
                                    unit_operand = req.payload.target_frame;
                                    state_next   = S_MUL;
                                end
                                else
                                begin
                                    pend_next = make_rsp(vbes_pkg::KIND_QUEUED,
                                                         req.payload.evt_id, '0, '0,
                                                         '0, 1'b0, 1'b1);
                                    ret_next   = S_IDLE;
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        vbes_pkg::CMD_ABORT, vbes_pkg::CMD_TICK:
                        begin
                            state_next = (count_reg != '0) ? S_SCAN_RD : S_SCAN_END;
                        end
                        default:
                        begin
                            // unused command code, nothing happens
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[IDX_W-1:0];
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                // compacting pass: survivors move down to wr_reg, which trails idx_reg
                idx_next = idx_inc;
                if (drop)
                begin
                    found_next = 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_reg[IDX_W-1:0];
                    wr_next   = wr_reg + CNT_W'(1);
                end
                if (drop && is_tick)
                begin
                    pend_next = make_rsp(vbes_pkg::KIND_NOTIFY, rd_id_reg,
                                         req_reg.now_time, req_reg.now_frame,
                                         '0, 1'b0, 1'b0);
                    ret_next   = more ? S_SCAN_RD : S_SCAN_END;
                    state_next = S_EMIT;
                end
                else if (more)
                begin
                    // read ahead of the write, addresses never meet
                    mem_re    = 1'b1;
                    mem_raddr = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                count_next = wr_reg;
                if (is_tick)
                begin
                    if (wr_reg != '0)
                    begin
                        // re-arm for the next frame
                        unit_ctl     = '{start: 1'b1, op: vbes_pkg::UOP_MUL};
                        unit_operand = next_frame_reg;
                        second_next  = 1'b1;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        pend_next = make_rsp(vbes_pkg::KIND_TICK_DONE, '0, '0, '0,
                                             '0, 1'b0, 1'b1);
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        pend_next = make_rsp(vbes_pkg::KIND_ABORTED, req_reg.evt_id,
                                             '0, '0, '0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        pend_next = make_rsp(vbes_pkg::KIND_MISS, '0, '0, '0,
                                             '0, 1'b0, 1'b1);
                    end
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                if (unit_sts.done)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // target time already passed: wake for the next frame instead
                if (!second_reg && (unit_time <= req_reg.now_time))
                begin
                    unit_ctl     = '{start: 1'b1, op: vbes_pkg::UOP_MUL};
                    unit_operand = next_frame_reg;
                    second_next  = 1'b1;
                    state_next   = S_MUL;
                end
                else
                begin
                    unit_ctl     = '{start: 1'b1, op: vbes_pkg::UOP_DIV};
                    unit_operand = unit_time;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (unit_sts.done)
                begin
                    if (req_reg.command == vbes_pkg::CMD_QUEUE)
                    begin
                        pend_next = make_rsp(vbes_pkg::KIND_QUEUED, req_reg.evt_id,
                                             '0, '0, unit_wake, 1'b1, 1'b1);
                    end
                    else
                    begin
                        pend_next = make_rsp(vbes_pkg::KIND_TICK_DONE, '0, '0, '0,
                                             unit_wake, 1'b1, 1'b1);
                    end
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait for room in the output register
                if (slot_free)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            req_reg        <= '0;
            next_frame_reg <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            wr_reg         <= '0;
            found_reg      <= 1'b0;
            second_reg     <= 1'b0;
            pend_reg       <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            req_reg        <= req_next;
            next_frame_reg <= next_frame_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            wr_reg         <= wr_next;
            found_reg      <= found_next;
            second_reg     <= second_next;
            pend_reg       <= pend_next;
            rsp_reg        <= rsp_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // checks on the sequencer and the table bookkeeping
    `VBES_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "pending count over depth")
    `VBES_ASSERT_NOW(a_wr_trails, state_reg == S_SCAN_CHK, wr_reg <= idx_reg, "compaction write ahead of read")
    `VBES_ASSERT_NOW(a_unit_done, unit_sts.done, (state_reg == S_MUL) || (state_reg == S_DIV), "time unit finished while not awaited")
    `VBES_ASSERT_NEXT(a_queue_count, req.valid && req.ready && (req.payload.command == vbes_pkg::CMD_QUEUE) && (count_reg < CNT_W'(TABLE_DEPTH)), count_reg == $past(count_reg) + CNT_W'(1), "queue did not grow the table")

endmodule

### test/tb.sv
// testbench for the vblank event scheduler: table mirror, directed and random commands
// depends on vbes_pkg and vbes_stream_if from the rtl, and on vblank_event_scheduler
`timescale 1ns / 100ps

module tb;

    import vbes_pkg::*;

    localparam int TABLE_SLOTS   = DEFAULT_TABLE_DEPTH;
    localparam int IDLE_PCT      = 24;
    localparam int SETTLE_CYCLES = 100;    // worst tick: full scan, notifies, wake math
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 62;
    localparam logic [TIME_W-1:0] US_PER_MS = 64'd1000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;   // spare command code, dropped by the block

    // what the sender does next
    typedef enum logic [2:0] {
        STEP_BEAT,      // offer one command beat
        STEP_WRITE,     // register write once the block has gone quiet
        STEP_DRAIN,     // wait until every expected result is in
        STEP_HOLD,      // tell the receiver to stop taking results for a while
        STEP_CALM       // switch random idling off (data 1) or back on (data 0)
    } step_kind_t;

    typedef struct {
        step_kind_t        kind;
        req_t              beat;
        cfg_index_t        index;
        logic [TIME_W-1:0] data;
    } plan_step_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]      cfg_data  = '0;

    vbes_stream_if #(.payload_t(req_t)) req_if ();
    vbes_stream_if #(.payload_t(rsp_t)) rsp_if ();

    vblank_event_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // mirror of the scheduler: register copies and the pending table
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]     base_time;
    logic [TIME_W-1:0]     base_frame;
    logic [INTERVAL_W-1:0] frame_us;
    logic [TIME_W-1:0]     held_ids     [TABLE_SLOTS];
    logic [TIME_W-1:0]     held_targets [TABLE_SLOTS];
    int                    held_count;

    rsp_t       awaited_results [$];   // results still owed by the block, oldest first
    plan_step_t plan [$];              // filled once at time zero, drained by the sender

    int   pending_n = 0;   // awaited_results size as of the last edge
    int   quiet     = 0;   // edges since the last beat on either channel
    int   failures  = 0;
    logic calm      = 1'b0;
    logic hold_req  = 1'b0;

    // microsecond time of frame f under a given base and interval, wrapping mod 2^64
    function automatic logic [TIME_W-1:0] span_time(input logic [TIME_W-1:0] tb0,
                                                    input logic [TIME_W-1:0] fb0,
                                                    input logic [INTERVAL_W-1:0] iv,
                                                    input logic [TIME_W-1:0] f);
        return tb0 + {{(TIME_W-INTERVAL_W){1'b0}}, iv} * (f - fb0);
    endfunction

    // wake in ms: one past the whole milliseconds, low 32 bits kept
    function automatic logic [WAKE_W-1:0] wake_of(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] ms;
        ms = t / US_PER_MS + 64'd1;
        return ms[WAKE_W-1:0];
    endfunction

    function automatic rsp_t make_result(input kind_t k, input logic [TIME_W-1:0] id,
                                         input logic [TIME_W-1:0] st,
                                         input logic [TIME_W-1:0] sf,
                                         input logic [WAKE_W-1:0] wake,
                                         input logic wv, input logic is_last);
        rsp_t r;
        r.kind        = k;
        r.done_id     = id;
        r.stamp_time  = st;
        r.stamp_frame = sf;
        r.wake_ms     = wake;
        r.wake_valid  = wv;
        r.last        = is_last;
        return r;
    endfunction

    // apply one accepted command to the table copy and queue the results it owes
    task automatic forecast_results(input req_t b);
        logic [TIME_W-1:0] due;
        int                hit;
        int                keep;
        case (b.command)
            CMD_QUEUE:
            begin
                if (held_count >= TABLE_SLOTS)
                    awaited_results.push_back(make_result(KIND_FULL, '0, '0, '0, '0,
                                                          1'b0, 1'b1));
                else
                begin
                    // target already in the past: wake for the next frame instead
                    due = span_time(base_time, base_frame, frame_us, b.target_frame);
                    if (due <= b.now_time)
                        due = span_time(base_time, base_frame, frame_us,
                                        b.now_frame + 64'd1);
                    // the wake is only armed when the table was empty
                    awaited_results.push_back(make_result(KIND_QUEUED, b.evt_id, '0, '0,
                        (held_count == 0) ? wake_of(due) : '0, held_count == 0, 1'b1));
                    held_ids[held_count]     = b.evt_id;
                    held_targets[held_count] = b.target_frame;
                    held_count++;
                end
            end
            CMD_ABORT:
            begin
                // first match in table order wins
                hit = -1;
                for (int i = 0; i < held_count; i++)
                    if (hit < 0 && held_ids[i] == b.evt_id)
                        hit = i;
                if (hit < 0)
                    awaited_results.push_back(make_result(KIND_MISS, '0, '0, '0, '0,
                                                          1'b0, 1'b1));
                else
                begin
                    for (int i = hit; i + 1 < held_count; i++)
                    begin
                        held_ids[i]     = held_ids[i+1];
                        held_targets[i] = held_targets[i+1];
                    end
                    held_count--;
                    awaited_results.push_back(make_result(KIND_ABORTED, b.evt_id, '0, '0,
                                                          '0, 1'b0, 1'b1));
                end
            end
            CMD_TICK:
            begin
                // notify reached entries in order, compact the survivors
                keep = 0;
                for (int i = 0; i < held_count; i++)
                begin
                    if (b.now_frame >= held_targets[i])
                        awaited_results.push_back(make_result(KIND_NOTIFY, held_ids[i],
                            b.now_time, b.now_frame, '0, 1'b0, 1'b0));
                    else
                    begin
                        held_ids[keep]     = held_ids[i];
                        held_targets[keep] = held_targets[i];
                        keep++;
                    end
                end
                held_count = keep;
                awaited_results.push_back(make_result(KIND_TICK_DONE, '0, '0, '0,
                    (held_count > 0) ? wake_of(span_time(base_time, base_frame, frame_us,
                                                         b.now_frame + 64'd1)) : '0,
                    held_count > 0, 1'b1));
            end
            default:
                ;   // spare command: nothing owed, nothing changes
        endcase
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // plan building
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    task automatic add_beat(input logic [1:0] c, input logic [TIME_W-1:0] id,
                            input logic [TIME_W-1:0] tgt, input logic [TIME_W-1:0] nf,
                            input logic [TIME_W-1:0] nt);
        plan_step_t s;
        s.kind               = STEP_BEAT;
        s.beat.command       = c;
        s.beat.evt_id        = id;
        s.beat.target_frame  = tgt;
        s.beat.now_frame     = nf;
        s.beat.now_time      = nt;
        s.index              = CFG_TIME_BASE;
        s.data               = '0;
        plan.push_back(s);
    endtask

    task automatic add_step(input step_kind_t k, input cfg_index_t idx,
                            input logic [TIME_W-1:0] data);
        plan_step_t s;
        s.kind  = k;
        s.beat  = '0;
        s.index = idx;
        s.data  = data;
        plan.push_back(s);
    endtask

    // drain, then load all three registers
    task automatic add_settings(input logic [TIME_W-1:0] tb0, input logic [TIME_W-1:0] fb0,
                                input logic [INTERVAL_W-1:0] iv);
        add_step(STEP_DRAIN, CFG_TIME_BASE, '0);
        add_step(STEP_WRITE, CFG_TIME_BASE, tb0);
        add_step(STEP_WRITE, CFG_FRAME_BASE, fb0);
        add_step(STEP_WRITE, CFG_FRAME_INTERVAL, {{(TIME_W-INTERVAL_W){1'b0}}, iv});
    endtask

    // a display-like command stream: frame counter moving forward, times close to
    // the frame times, targets a few frames ahead or behind, aborts of ids recently queued;
    // a burst past the table size, a mid-phase drain, and some raw noise
    task automatic add_random_phase(input int n_items, input logic [TIME_W-1:0] tb0,
                                    input logic [TIME_W-1:0] fb0,
                                    input logic [INTERVAL_W-1:0] iv);
        logic [TIME_W-1:0] cur;
        logic [TIME_W-1:0] nt;
        logic [TIME_W-1:0] id;
        logic [TIME_W-1:0] tgt;
        logic [TIME_W-1:0] recent [$];
        logic [1:0]        c;
        int                made;
        int                roll;
        bit                burst_done;
        bit                drain_done;
        cur        = fb0 + 64'($urandom_range(0, 40));
        made       = 0;
        burst_done = 1'b0;
        drain_done = 1'b0;
        while (made < n_items)
        begin
            // jitter of about half a frame either side of the frame time
            nt   = span_time(tb0, fb0, iv, cur) + 64'($urandom_range(0, iv)) - 64'(iv / 2);
            roll = $urandom_range(0, 99);
            if (!burst_done && made >= n_items / 3)
            begin
                burst_done = 1'b1;
                repeat (TABLE_SLOTS + 2)
                begin
                    id = 64'($urandom_range(0, 15));
                    recent.push_back(id);
                    add_beat(CMD_QUEUE, id, cur + 64'($urandom_range(3, 12)), cur, nt);
                end
                made += TABLE_SLOTS + 2;
            end
            else if (!drain_done && made >= (2 * n_items) / 3)
            begin
                drain_done = 1'b1;
                add_step(STEP_DRAIN, CFG_TIME_BASE, '0);
            end
            else if (roll < 12)
            begin
                c = 2'($urandom_range(0, 3));
                add_beat(c, wide_random(), wide_random(), wide_random(), wide_random());
                if (c != CMD_UNUSED)
                    made++;
            end
            else if (roll < 55)
            begin
                id  = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 15)) : wide_random();
                tgt = ($urandom_range(0, 4) == 0) ? cur - 64'($urandom_range(0, 3))
                                                  : cur + 64'($urandom_range(0, 6));
                recent.push_back(id);
                add_beat(CMD_QUEUE, id, tgt, cur, nt);
                made++;
            end
            else if (roll < 68)
            begin
                if (recent.size() > 0 && $urandom_range(0, 9) < 7)
                    id = recent[$urandom_range(0, recent.size() - 1)];
                else
                    id = wide_random();
                add_beat(CMD_ABORT, id, wide_random(), cur, nt);
                made++;
            end
            else
            begin
                add_beat(CMD_TICK, wide_random(), wide_random(), cur, nt);
                cur += 64'($urandom_range(0, 3));
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sender: one command beat or one register write per edge, from the plan
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic                   next_valid;
        req_t                   next_beat;
        logic                   next_we;
        logic [CFG_INDEX_W-1:0] next_index;
        logic [TIME_W-1:0]      next_data;
        logic                   next_calm;
        logic                   next_hold;
        logic                   settled;
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
            cfg_we         <= 1'b0;
            cfg_index      <= '0;
            cfg_data       <= '0;
            calm           <= 1'b0;
            hold_req       <= 1'b0;
        end
        else
        begin
            next_valid = req_if.valid;
            next_beat  = req_if.payload;
            next_we    = 1'b0;
            next_index = cfg_index;
            next_data  = cfg_data;
            next_calm  = calm;
            next_hold  = 1'b0;
            // a beat offered here at this edge is not yet seen by the counters
            settled = (pending_n == 0) && (quiet >= SETTLE_CYCLES) && !req_if.valid;
            // a beat on offer stays put until taken
            if (!(req_if.valid && !req_if.ready))
            begin
                next_valid = 1'b0;
                if (plan.size() > 0)
                begin
                    case (plan[0].kind)
                        STEP_BEAT:
                        begin
                            if (calm || $urandom_range(0, 99) >= IDLE_PCT)
                            begin
                                next_valid = 1'b1;
                                next_beat  = plan[0].beat;
                                void'(plan.pop_front());
                            end
                        end
                        STEP_WRITE:
                        begin
                            if (settled)
                            begin
                                next_we    = 1'b1;
                                next_index = plan[0].index;
                                next_data  = plan[0].data;
                                void'(plan.pop_front());
                            end
                        end
                        STEP_DRAIN:
                        begin
                            if (settled)
                                void'(plan.pop_front());
                        end
                        STEP_HOLD:
                        begin
                            next_hold = 1'b1;
                            void'(plan.pop_front());
                        end
                        STEP_CALM:
                        begin
                            next_calm = plan[0].data[0];
                            void'(plan.pop_front());
                        end
                        default:
                            void'(plan.pop_front());
                    endcase
                end
            end
            req_if.valid   <= next_valid;
            req_if.payload <= next_beat;
            cfg_we         <= next_we;
            cfg_index      <= next_index;
            cfg_data       <= next_data;
            calm           <= next_calm;
            hold_req       <= next_hold;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int hold_left;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_req)
        begin
            rsp_if.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // monitor: mirrors register writes, predicts on command beats, checks result beats
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        rsp_t got;
        logic req_beat;
        logic rsp_beat;
        if (!rst_n)
        begin
            base_time  = TIME_BASE_RST;
            base_frame = FRAME_BASE_RST;
            frame_us   = FRAME_INTERVAL_RST;
            held_count = 0;
            awaited_results.delete();
            pending_n <= 0;
            quiet     <= 0;
        end
        else
        begin
            req_beat = req_if.valid && req_if.ready;
            rsp_beat = rsp_if.valid && rsp_if.ready;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIME_BASE:      base_time  = cfg_data;
                    CFG_FRAME_BASE:     base_frame = cfg_data;
                    CFG_FRAME_INTERVAL: frame_us   = cfg_data[INTERVAL_W-1:0];
                    default:            ;
                endcase
            end
            if (req_beat)
                forecast_results(req_if.payload);
            if (rsp_beat)
            begin
                got = rsp_if.payload;
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d id %h",
                           got.kind, got.done_id);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("kind",        want.kind,        got.kind);
                    check_field("done_id",     want.done_id,     got.done_id);
                    check_field("stamp_time",  want.stamp_time,  got.stamp_time);
                    check_field("stamp_frame", want.stamp_frame, got.stamp_frame);
                    check_field("wake_ms",     want.wake_ms,     got.wake_ms);
                    check_field("wake_valid",  want.wake_valid,  got.wake_valid);
                    check_field("last",        want.last,        got.last);
                end
            end
            pending_n <= awaited_results.size();
            if (req_beat || rsp_beat)
                quiet <= 0;
            else if (quiet < SETTLE_CYCLES)
                quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus plan, reset, end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [TIME_W-1:0]     rand_tb;
        logic [TIME_W-1:0]     rand_fb;
        logic [INTERVAL_W-1:0] rand_iv;

        // directed part, reset register values
        add_beat(CMD_TICK, '0, '0, '0, '0);               // tick on an empty table
        add_beat(CMD_ABORT, '0, '0, '0, '0);              // abort with nothing queued
        add_beat(CMD_UNUSED, '1, '1, '1, '1);             // spare command is dropped
        add_beat(CMD_QUEUE, '0, '0, '0, '0);              // target time already passed
        // fill the table; id 7 twice, last entry at the far end of the frame range
        for (int k = 1; k <= TABLE_SLOTS - 1; k++)
        begin
            if (k == TABLE_SLOTS - 1)
                add_beat(CMD_QUEUE, '1, '1, '0, '0);
            else
                add_beat(CMD_QUEUE, (k == TABLE_SLOTS - 2) ? 64'd7 : 64'(k), 64'(k), '0, '0);
        end
        add_beat(CMD_QUEUE, 64'd99, 64'd1, '0, '0);       // table full
        add_beat(CMD_ABORT, 64'd7, '0, '0, '0);           // first of two matches goes
        add_beat(CMD_TICK, '0, '0, 64'd6, 64'd100000);    // partial tick, wake re-armed
        add_beat(CMD_TICK, '0, '0, '1, '1);               // everything fires
        add_beat(CMD_QUEUE, '1, '1, '0, '0);              // future target on empty table
        add_beat(CMD_ABORT, '1, '0, '0, '0);

        // high extremes; receiver stalls long at the start so the block backs up
        add_settings('1, '1, 20'd1000000);
        add_step(STEP_HOLD, CFG_TIME_BASE, '0);
        add_random_phase(PHASE_ITEMS, '1, '1, 20'd1000000);

        // low extremes, with no idling on either side
        add_settings('0, '0, 20'd1);
        add_step(STEP_CALM, CFG_TIME_BASE, 64'd1);
        add_random_phase(PHASE_ITEMS, '0, '0, 20'd1);
        add_step(STEP_CALM, CFG_TIME_BASE, 64'd0);

        // arbitrary bases and interval
        rand_tb = wide_random();
        rand_fb = wide_random();
        rand_iv = 20'($urandom_range(1, 1000000));
        add_settings(rand_tb, rand_fb, rand_iv);
        add_random_phase(PHASE_ITEMS, rand_tb, rand_fb, rand_iv);

        // 60 Hz interval on random bases
        rand_tb = wide_random();
        rand_fb = wide_random();
        add_settings(rand_tb, rand_fb, FRAME_INTERVAL_RST);
        add_random_phase(PHASE_ITEMS, rand_tb, rand_fb, FRAME_INTERVAL_RST);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // plan used up, nothing owed, and the block quiet for a while
        @(negedge clk);
        while (plan.size() != 0 || req_if.valid || pending_n != 0 || quiet < SETTLE_CYCLES)
            @(negedge clk);

        if (failures == 0)
            $display("vblank_event_scheduler verification clean");
        else
            $display("vblank_event_scheduler verification failed");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin : watchdog
        #2_000_000;
        $display("vblank_event_scheduler verification failed");
        $finish;
    end

endmodule
